// ----- sv/pct_pkg.sv -----
// Package for the prime chain tracker: beat payload structs, operation codes,
// entry state codes, response status codes, CSR indexes and parameter defaults.
// No dependencies.
package pct_pkg;

   localparam int MAX_ENTRIES_DEF = 32;
   localparam int OFFSET_BITS_DEF = 16;

   // operation codes carried in req func
   localparam logic [2:0] FN_OPEN   = 3'd0;
   localparam logic [2:0] FN_APPEND = 3'd1;
   localparam logic [2:0] FN_FETCH  = 3'd2;
   localparam logic [2:0] FN_REPORT = 3'd3;
   localparam logic [2:0] FN_EVAL   = 3'd4;

   // per-entry test state
   localparam logic [1:0] ENT_UNTESTED = 2'd0;
   localparam logic [1:0] ENT_PASS     = 2'd1;
   localparam logic [1:0] ENT_FAIL     = 2'd2;

   // response status
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_NOPEND = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_GAP   = 2'd0;
   localparam logic [1:0] CSR_MIN_LEN   = 2'd1;
   localparam logic [1:0] CSR_KEEPALIVE = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] chain_base;
      logic [15:0] offset;
      logic        prime_flag;
   } pct_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] base_out;
      logic [15:0] candidate_offset;
      logic [15:0] run_start;
      logic [5:0]  run_length;
      logic        hope;
      logic [5:0]  entry_count;
   } pct_rsp_type;

endpackage

// ----- sv/prime_chain_tracker.sv -----
// Prime chain tracker top level: offset/state tables, walk sequencer, config
// registers and response register.
// Depends on pct_pkg.
//
// Usage: one request beat on req_ (valid/stall) yields exactly one response
// beat on rsp_ (valid/stall). req_stall stays high from the accepted beat
// until its response is taken, so one operation is in flight at a time.
// The next request can be taken from the cycle after the response beat.
// Open, append, report and unknown codes answer in the cycle after acceptance.
// Fetch and evaluate walk the table through one registered read port, one
// entry per cycle; fetch stops at the first untested entry.
// Evaluate tracks the strict and the optimistic run in the same pass.
// A stalled response holds its payload and keeps req_stall high.
// csr_ writes (index 0 max_gap, 1 min_chain_length, 2 keepalive_count) are
// always taken; other indexes are dropped. Write them only while idle.
// Synchronous reset empties the chain, clears the base and restores the
// register defaults; the tables themselves are not cleared.
module prime_chain_tracker #(
   parameter int MAX_ENTRIES = pct_pkg::MAX_ENTRIES_DEF,
   parameter int OFFSET_BITS = pct_pkg::OFFSET_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pct_pkg::pct_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pct_pkg::pct_rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import pct_pkg::*;

   localparam int OB    = OFFSET_BITS;
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int GAP_W = ((OB > 16) ? OB : 16) + 2;
   localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 2;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   typedef struct packed {
      logic [CNT_W-1:0] run;
      logic [OB-1:0]    run_st;
      logic [OB-1:0]    last;
      logic [CNT_W-1:0] best_len;
      logic [OB-1:0]    best_st;
   } trk_type;

   // one entry of the run walk; gap is measured from the last passed offset
   function automatic trk_type trk_step(trk_type t, logic pass, logic [OB-1:0] cur,
                                        logic [15:0] mg);
      trk_type r;
      logic signed [GAP_W-1:0] gap;
      r = t;
      gap = $signed(GAP_W'(cur)) - $signed(GAP_W'(t.last));
      if (t.run != '0 && gap > $signed(GAP_W'(mg))) begin
         if (t.run > t.best_len) begin
            r.best_len = t.run;
            r.best_st  = t.run_st;
         end
         r.run = '0;
      end
      if (pass) begin
         if (r.run == '0) begin
            r.run_st = cur;
         end
         r.run  = r.run + 1'b1;
         r.last = cur;
      end
      return r;
   endfunction

   function automatic trk_type trk_close(trk_type t);
      trk_type r;
      r = t;
      if (t.run > t.best_len) begin
         r.best_len = t.run;
         r.best_st  = t.run_st;
      end
      return r;
   endfunction

   // tables
   logic [OB-1:0] off_mem [MAX_ENTRIES];
   logic [1:0]    st_mem  [MAX_ENTRIES];
   logic [OB-1:0] rd_off_ff;
   logic [1:0]    rd_st_ff;
   logic             off_we, st_we;
   logic [IDX_W-1:0] off_wa, st_wa, rd_addr;
   logic [OB-1:0]    off_wd;
   logic [1:0]       st_wd;

   // control and chain state
   logic [1:0]       state_ff, state_in;
   logic [63:0]      base_ff, base_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] untested_ff, untested_in;
   logic [CNT_W-1:0] prime_ff, prime_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [15:0]      max_gap_ff;
   logic [5:0]       min_len_ff, keep_ff;

   // walk
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic [IDX_W-1:0] proc_ff, proc_in;
   logic             q_vld_ff, q_vld_in;
   logic             fetch_ff, fetch_in;
   trk_type          trk_p_ff, trk_p_in, trk_o_ff, trk_o_in;
   trk_type          fin_p, fin_o;

   // result payload
   logic [1:0]  res_status_ff, res_status_in;
   logic [15:0] res_cand_ff, res_cand_in;
   logic [15:0] res_bstart_ff, res_bstart_in;
   logic [5:0]  res_blen_ff, res_blen_in;
   logic        res_hope_ff, res_hope_in;

   logic [CMP_W-1:0] prime_x, untested_x;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign csr_ready = 1'b1;
   assign rd_addr   = iss_ff[IDX_W-1:0];
   assign prime_x   = CMP_W'(prime_ff);
   assign untested_x = CMP_W'(untested_ff);

   always_comb begin
      rsp_data.status           = res_status_ff;
      rsp_data.base_out         = base_ff;
      rsp_data.candidate_offset = res_cand_ff;
      rsp_data.run_start        = res_bstart_ff;
      rsp_data.run_length       = res_blen_ff;
      rsp_data.hope             = res_hope_ff;
      rsp_data.entry_count      = 6'(count_ff);
   end

   always_comb begin
      fin_p = trk_close(trk_p_ff);
      fin_o = trk_close(trk_o_ff);
   end

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      untested_in   = untested_ff;
      prime_in      = prime_ff;
      pend_idx_in   = pend_idx_ff;
      pend_vld_in   = pend_vld_ff;
      iss_in        = iss_ff;
      proc_in       = proc_ff;
      q_vld_in      = 1'b0;
      fetch_in      = fetch_ff;
      trk_p_in      = trk_p_ff;
      trk_o_in      = trk_o_ff;
      res_status_in = res_status_ff;
      res_cand_in   = res_cand_ff;
      res_bstart_in = res_bstart_ff;
      res_blen_in   = res_blen_ff;
      res_hope_in   = res_hope_ff;
      off_we        = 1'b0;
      off_wa        = '0;
      off_wd        = '0;
      st_we         = 1'b0;
      st_wa         = '0;
      st_wd         = ENT_UNTESTED;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_status_in = STAT_OK;
               res_cand_in   = '0;
               res_bstart_in = '0;
               res_blen_in   = '0;
               res_hope_in   = 1'b0;
               state_in      = ST_RESP;
               case (req_data.func)
                  FN_OPEN: begin
                     base_in     = req_data.chain_base;
                     off_we      = 1'b1;
                     st_we       = 1'b1;
                     count_in    = CNT_W'(1);
                     untested_in = CNT_W'(1);
                     prime_in    = '0;
                     pend_vld_in = 1'b0;
                     pend_idx_in = '0;
                  end
                  FN_APPEND: begin
                     if (count_ff >= CNT_MAX) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        off_we      = 1'b1;
                        off_wa      = count_ff[IDX_W-1:0];
                        off_wd      = OB'(req_data.offset);
                        st_we       = 1'b1;
                        st_wa       = count_ff[IDX_W-1:0];
                        count_in    = count_ff + 1'b1;
                        untested_in = untested_ff + 1'b1;
                     end
                  end
                  FN_REPORT: begin
                     if (!pend_vld_ff || CNT_W'(pend_idx_ff) >= count_ff) begin
                        res_status_in = STAT_NOPEND;
                     end else begin
                        if (untested_ff != '0) begin
                           untested_in = untested_ff - 1'b1;
                        end
                        st_we = 1'b1;
                        st_wa = pend_idx_ff;
                        if (req_data.prime_flag) begin
                           st_wd    = ENT_PASS;
                           prime_in = prime_ff + 1'b1;
                        end else begin
                           st_wd = ENT_FAIL;
                        end
                        pend_vld_in = 1'b0;
                     end
                  end
                  FN_FETCH, FN_EVAL: begin
                     state_in = ST_WALK;
                     fetch_in = (req_data.func == FN_FETCH);
                     iss_in   = '0;
                     proc_in  = '0;
                     trk_p_in = '0;
                     trk_o_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (q_vld_ff && fetch_ff && rd_st_ff == ENT_UNTESTED) begin
               // first untested entry found
               res_cand_in   = 16'(rd_off_ff);
               res_status_in = STAT_OK;
               pend_idx_in   = proc_ff;
               pend_vld_in   = 1'b1;
               state_in      = ST_RESP;
            end else begin
               if (q_vld_ff) begin
                  proc_in = proc_ff + 1'b1;
                  if (!fetch_ff) begin
                     trk_p_in = trk_step(trk_p_ff, rd_st_ff == ENT_PASS, rd_off_ff,
                                         max_gap_ff);
                     trk_o_in = trk_step(trk_o_ff,
                                         rd_st_ff == ENT_PASS || rd_st_ff == ENT_UNTESTED,
                                         rd_off_ff, max_gap_ff);
                  end
               end
               if (iss_ff < count_ff) begin
                  iss_in   = iss_ff + 1'b1;
                  q_vld_in = 1'b1;
               end else if (!q_vld_ff) begin
                  state_in = ST_RESP;
                  if (fetch_ff) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     res_bstart_in = 16'(fin_p.best_st);
                     res_blen_in   = 6'(fin_p.best_len);
                     if (untested_ff == '0) begin
                        res_hope_in = 1'b0;
                     end else if (prime_x >= CMP_W'(keep_ff)) begin
                        res_hope_in = 1'b1;
                     end else if (prime_x + untested_x < CMP_W'(min_len_ff)) begin
                        res_hope_in = 1'b0;
                     end else begin
                        res_hope_in = (CMP_W'(fin_o.best_len) >= CMP_W'(min_len_ff));
                     end
                  end
               end
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_off_ff <= off_mem[rd_addr];
      if (off_we) begin
         off_mem[off_wa] <= off_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_st_ff <= st_mem[rd_addr];
      if (st_we) begin
         st_mem[st_wa] <= st_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         base_ff     <= '0;
         count_ff    <= '0;
         untested_ff <= '0;
         prime_ff    <= '0;
         pend_idx_ff <= '0;
         pend_vld_ff <= 1'b0;
         q_vld_ff    <= 1'b0;
         max_gap_ff  <= 16'd12;
         min_len_ff  <= 6'd8;
         keep_ff     <= 6'd8;
      end else begin
         state_ff    <= state_in;
         base_ff     <= base_in;
         count_ff    <= count_in;
         untested_ff <= untested_in;
         prime_ff    <= prime_in;
         pend_idx_ff <= pend_idx_in;
         pend_vld_ff <= pend_vld_in;
         q_vld_ff    <= q_vld_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_GAP:   max_gap_ff <= csr_wdata;
               CSR_MIN_LEN:   min_len_ff <= csr_wdata[5:0];
               CSR_KEEPALIVE: keep_ff    <= csr_wdata[5:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      iss_ff        <= iss_in;
      proc_ff       <= proc_in;
      fetch_ff      <= fetch_in;
      trk_p_ff      <= trk_p_in;
      trk_o_ff      <= trk_o_in;
      res_status_ff <= res_status_in;
      res_cand_ff   <= res_cand_in;
      res_bstart_ff <= res_bstart_in;
      res_blen_ff   <= res_blen_in;
      res_hope_ff   <= res_hope_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("entry count above table depth");

   a_tally_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(prime_ff) + CMP_W'(untested_ff) <= CMP_W'(count_ff))
      else $error("prime plus untested exceeds entry count");

   a_pend_in_table: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> CNT_W'(pend_idx_ff) < count_ff)
      else $error("pending fetch points past the table");

   a_read_only_walk: assert property (@(posedge clock) disable iff (reset)
      q_vld_ff |-> state_ff == ST_WALK)
      else $error("table read beat outside a walk");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

// ----- sim/tb_prime_chain_tracker.sv -----
// Testbench for prime_chain_tracker: directed and random request beats, with
// every response checked field by field against a built-in tracker model.
// Depends on pct_pkg and prime_chain_tracker.
`timescale 1ns / 1ps

module tb_prime_chain_tracker;
   import pct_pkg::*;

   localparam int ENTRIES = MAX_ENTRIES_DEF;
   localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;

   typedef struct packed {
      logic [15:0] start_off;
      logic [5:0]  run_len;
   } run_span_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   pct_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   pct_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   prime_chain_tracker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // tracker model state
   logic [63:0] trk_base;
   logic [15:0] trk_offset [0:ENTRIES-1];
   logic [1:0]  trk_state [0:ENTRIES-1];
   int          trk_count;
   int          trk_untested;
   int          trk_primes;
   int          trk_pend_idx;
   bit          trk_pend;
   int          cfg_max_gap;
   int          cfg_min_len;
   int          cfg_keepalive;

   pct_rsp_type awaited_answers [$];

   int  errors = 0;
   int  beats_sent = 0;
   int  answers_checked = 0;
   int  full_answers = 0;
   int  nopend_answers = 0;
   int  hopeful_evals = 0;
   int  hold_off_cycles = 0;
   bit  send_idle = 1'b1;
   bit  recv_idle = 1'b1;

   function automatic void reset_tracker();
      trk_base = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         trk_offset[i] = '0;
         trk_state[i] = ENT_UNTESTED;
      end
      trk_count = 0;
      trk_untested = 0;
      trk_primes = 0;
      trk_pend_idx = 0;
      trk_pend = 1'b0;
      cfg_max_gap = 12;
      cfg_min_len = 8;
      cfg_keepalive = 8;
   endfunction

   // longest run of passed entries; optimistic counts untested as passed
   function automatic run_span_type longest_run(input bit optimistic);
      run_span_type span;
      int        best_len, best_st, run_len, run_st;
      longint    acc_gap, prev_off, cur_off;
      bit        counts;
      span = '0;
      best_len = 0;
      best_st = 0;
      run_len = 0;
      run_st = 0;
      acc_gap = 0;
      if (trk_count == 0)
         return span;
      prev_off = trk_offset[0];
      for (int i = 0; i < trk_count; i++) begin
         cur_off = trk_offset[i];
         counts = (trk_state[i] == ENT_PASS) ||
                  (optimistic && trk_state[i] == ENT_UNTESTED);
         // signed gap: a step back shrinks it
         if (run_len > 0)
            acc_gap += cur_off - prev_off;
         if (acc_gap > cfg_max_gap) begin
            if (run_len > best_len) begin
               best_len = run_len;
               best_st = run_st;
            end
            run_len = 0;
            acc_gap = 0;
         end
         if (counts) begin
            run_len++;
            acc_gap = 0;
            if (run_len == 1)
               run_st = int'(cur_off);
         end
         prev_off = cur_off;
      end
      if (run_len > best_len) begin
         best_len = run_len;
         best_st = run_st;
      end
      span.start_off = 16'(best_st);
      span.run_len = 6'(best_len);
      return span;
   endfunction

   function automatic pct_rsp_type track_beat(input pct_req_type beat);
      pct_rsp_type  ans;
      run_span_type span;
      bit           found;
      ans = '0;
      found = 1'b0;
      case (beat.func)
         FN_OPEN: begin
            trk_base = beat.chain_base;
            trk_offset[0] = '0;
            trk_state[0] = ENT_UNTESTED;
            trk_count = 1;
            trk_untested = 1;
            trk_primes = 0;
            trk_pend = 1'b0;
            trk_pend_idx = 0;
         end
         FN_APPEND: begin
            if (trk_count >= ENTRIES) begin
               ans.status = STAT_FULL;
            end else begin
               trk_offset[trk_count] = beat.offset;
               trk_state[trk_count] = ENT_UNTESTED;
               trk_count++;
               trk_untested++;
            end
         end
         FN_FETCH: begin
            ans.status = STAT_FULL;
            for (int i = 0; i < trk_count && !found; i++) begin
               if (trk_state[i] == ENT_UNTESTED) begin
                  found = 1'b1;
                  ans.candidate_offset = trk_offset[i];
                  ans.status = STAT_OK;
                  trk_pend_idx = i;
                  trk_pend = 1'b1;
               end
            end
         end
         FN_REPORT: begin
            if (!trk_pend || trk_pend_idx >= trk_count) begin
               ans.status = STAT_NOPEND;
            end else begin
               if (trk_untested > 0)
                  trk_untested--;
               if (beat.prime_flag) begin
                  trk_state[trk_pend_idx] = ENT_PASS;
                  trk_primes++;
               end else begin
                  trk_state[trk_pend_idx] = ENT_FAIL;
               end
               trk_pend = 1'b0;
            end
         end
         FN_EVAL: begin
            span = longest_run(1'b0);
            ans.run_start = span.start_off;
            ans.run_length = span.run_len;
            if (trk_untested == 0) begin
               ans.hope = 1'b0;
            end else if (trk_primes >= cfg_keepalive) begin
               ans.hope = 1'b1;
            end else if (trk_primes + trk_untested < cfg_min_len) begin
               ans.hope = 1'b0;
            end else begin
               span = longest_run(1'b1);
               ans.hope = (int'(span.run_len) >= cfg_min_len);
            end
         end
         default: ;
      endcase
      ans.base_out = trk_base;
      ans.entry_count = trk_count[5:0];
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("MISMATCH at response %0d: %s got %0h want %0h",
               answers_checked, what, got, want);
   endtask

   function automatic pct_req_type noise_beat(input logic [2:0] fn);
      pct_req_type beat;
      beat.func = fn;
      beat.chain_base = {$urandom, $urandom};
      beat.offset = 16'($urandom);
      beat.prime_flag = 1'($urandom);
      return beat;
   endfunction

   function automatic logic [15:0] next_offset(input logic [15:0] prev);
      int          pick;
      logic [15:0] step;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         step = 16'($urandom_range(1, 6));
         return prev + step;
      end else if (pick < 78) begin
         step = 16'($urandom_range(7, 20));
         return prev + step;
      end else if (pick < 88) begin
         step = 16'($urandom_range(1, 8));
         return prev - step;
      end else if (pick < 94) begin
         return prev;
      end
      step = 16'($urandom);
      return step;
   endfunction

   // valid drops at the accepting edge; each beat begins on a fresh clock edge
   task automatic send_item(input pct_req_type beat);
      int          gap;
      pct_rsp_type want;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      @(posedge clock);
      repeat (gap) @(posedge clock);
      req_data <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      req_valid <= 1'b0;
      want = track_beat(beat);
      awaited_answers = {awaited_answers, want};
      beats_sent++;
   endtask

   task automatic wait_all_answered();
      while (awaited_answers.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAX_GAP:   cfg_max_gap = int'(value);
         CSR_MIN_LEN:   cfg_min_len = int'(value[5:0]);
         CSR_KEEPALIVE: cfg_keepalive = int'(value[5:0]);
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int max_gap, input int min_len, input int keep);
      wait_all_answered();
      write_csr(CSR_MAX_GAP, 16'(max_gap));
      write_csr(CSR_MIN_LEN, 16'(min_len));
      write_csr(CSR_KEEPALIVE, 16'(keep));
   endtask

   // open, append, then mostly fetch/report pairs with some noise mixed in
   task automatic run_chain(input int max_len);
      int          n_app, rounds, pick;
      logic [15:0] off;
      pct_req_type beat;
      send_item(noise_beat(FN_OPEN));
      off = '0;
      n_app = $urandom_range(0, max_len);
      for (int k = 0; k < n_app; k++) begin
         off = next_offset(off);
         beat = noise_beat(FN_APPEND);
         beat.offset = off;
         send_item(beat);
      end
      rounds = 0;
      while (trk_untested != 0 && rounds < 2 * n_app + 4) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_item(noise_beat(FN_FETCH));
            beat = noise_beat(FN_REPORT);
            beat.prime_flag = ($urandom_range(0, 99) < 65);
            send_item(beat);
         end else if (pick < 85) begin
            send_item(noise_beat(FN_EVAL));
         end else if (pick < 90) begin
            send_item(noise_beat(FN_REPORT));
         end else if (pick < 94) begin
            send_item(noise_beat(FN_FETCH));
         end else if (pick < 97) begin
            off = next_offset(off);
            beat = noise_beat(FN_APPEND);
            beat.offset = off;
            send_item(beat);
         end else begin
            send_item(noise_beat(3'(FN_UNUSED_FIRST + $urandom_range(0, 2))));
         end
         rounds++;
      end
      send_item(noise_beat(FN_EVAL));
   endtask

   task automatic run_chains_until(input int quota);
      int stop_at;
      stop_at = beats_sent + quota;
      while (beats_sent < stop_at)
         run_chain(($urandom_range(0, 4) == 0) ? 34 : 12);
   endtask

   task automatic test_empty_table();
      send_item(noise_beat(FN_EVAL));
      send_item(noise_beat(FN_FETCH));
      send_item(noise_beat(FN_REPORT));
      for (int k = 0; k < 3; k++)
         send_item(noise_beat(3'(FN_UNUSED_FIRST + k)));
   endtask

   task automatic test_chain_ops();
      logic [15:0] offs [6] = '{16'd2, 16'd4, 16'd6, 16'd30, 16'd28, 16'hFFFF};
      pct_req_type beat;
      beat = noise_beat(FN_OPEN);
      beat.chain_base = '1;
      send_item(beat);
      for (int k = 0; k < 6; k++) begin
         beat = noise_beat(FN_APPEND);
         beat.offset = offs[k];
         send_item(beat);
      end
      send_item(noise_beat(FN_FETCH));
      send_item(noise_beat(FN_FETCH));      // same entry again until reported
      beat = noise_beat(FN_REPORT);
      beat.prime_flag = 1'b1;
      send_item(beat);
      send_item(beat);                      // second report has nothing pending
      send_item(noise_beat(FN_FETCH));
      beat.prime_flag = 1'b0;
      send_item(beat);
      send_item(noise_beat(FN_FETCH));
      beat.prime_flag = 1'b1;
      send_item(beat);
      send_item(noise_beat(FN_EVAL));
      beat = noise_beat(FN_OPEN);
      beat.chain_base = '0;
      send_item(beat);
      send_item(noise_beat(FN_EVAL));
   endtask

   // receiver holds responses while the sender keeps offering beats
   task automatic test_backpressure();
      wait_all_answered();
      hold_off_cycles = 90;
      run_chain(8);
      hold_off_cycles = 120;
      run_chain(34);
   endtask

   task automatic test_drain_pause();
      run_chain(10);
      wait_all_answered();
      repeat ($urandom_range(1, 20)) @(posedge clock);
      run_chain(10);
   endtask

   task automatic test_config_sweep();
      apply_setting(0, 0, 0);
      run_chains_until(110);
      apply_setting(65535, 32, 32);
      run_chains_until(110);
      apply_setting(3, 5, 32);
      run_chains_until(110);
      apply_setting(40, 32, 4);
      run_chains_until(110);
      apply_setting(1, 1, 1);
      run_chains_until(110);
      apply_setting(12, 8, 8);
      run_chains_until(110);
   endtask

   task automatic test_no_idle();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      run_chains_until(120);
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   task automatic test_random_chains();
      apply_setting($urandom_range(4, 20), $urandom_range(4, 12), $urandom_range(6, 14));
      run_chains_until(500);
   endtask

   task automatic finish_run();
      int guard;
      guard = 0;
      while (awaited_answers.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      while (awaited_answers.size() != 0) begin
         report_mismatch("response never arrived", '0, 64'(awaited_answers.size()));
         void'(awaited_answers.pop_front());
      end
      $display("Sent %0d request beats, checked %0d responses across several settings",
               beats_sent, answers_checked);
      $display("Seen: %0d full/none-untested, %0d no-pending, %0d hopeful evaluates",
               full_answers, nopend_answers, hopeful_evals);
      if (errors == 0)
         $display("tb_prime_chain_tracker OK");
      else
         $display("tb_prime_chain_tracker NOT OK");
      $finish;
   endtask

   // response side: random stall per beat, plus long hold-offs on request
   initial begin : rsp_side
      int gap;
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else begin
            gap = recv_idle ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && reset === 1'b0));
      end
   end

   always @(posedge clock) begin : rsp_check
      pct_rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         answers_checked++;
         if (awaited_answers.size() == 0) begin
            report_mismatch("response with nothing expected", 64'(rsp_data.status), '0);
         end else begin
            want = awaited_answers.pop_front();
            if (want.status == STAT_FULL)
               full_answers++;
            if (want.status == STAT_NOPEND)
               nopend_answers++;
            if (want.hope)
               hopeful_evals++;
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.base_out !== want.base_out)
               report_mismatch("base_out", rsp_data.base_out, want.base_out);
            if (rsp_data.candidate_offset !== want.candidate_offset)
               report_mismatch("candidate_offset", 64'(rsp_data.candidate_offset),
                               64'(want.candidate_offset));
            if (rsp_data.run_start !== want.run_start)
               report_mismatch("run_start", 64'(rsp_data.run_start),
                               64'(want.run_start));
            if (rsp_data.run_length !== want.run_length)
               report_mismatch("run_length", 64'(rsp_data.run_length),
                               64'(want.run_length));
            if (rsp_data.hope !== want.hope)
               report_mismatch("hope", 64'(rsp_data.hope), 64'(want.hope));
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch("entry_count", 64'(rsp_data.entry_count),
                               64'(want.entry_count));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d responses outstanding", awaited_answers.size());
      $display("tb_prime_chain_tracker NOT OK");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MAX_GAP;
      csr_wdata <= '0;
      reset_tracker();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_chain_ops();
      test_backpressure();
      test_drain_pause();
      test_config_sweep();
      test_no_idle();
      test_random_chains();
      finish_run();
   end

endmodule

// ----- prime_chain_tracker.f -----
sv/pct_pkg.sv
sv/prime_chain_tracker.sv
sim/tb_prime_chain_tracker.sv
